@@ rtl/tcf_pkg.sv @@
// Shared types, constants and tables for the tracking camera follower.
// No dependencies; used by every module of the block.
`default_nettype none
package tcf_pkg;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_START = 12'b0000_0000_0010,
		S_SQ1   = 12'b0000_0000_0100,
		S_SQ2   = 12'b0000_0000_1000,
		S_CORD  = 12'b0000_0001_0000,
		S_ANG   = 12'b0000_0010_0000,
		S_MOVX  = 12'b0000_0100_0000,
		S_MOVY  = 12'b0000_1000_0000,
		S_DPREP = 12'b0001_0000_0000,
		S_DWAIT = 12'b0010_0000_0000,
		S_SHK   = 12'b0100_0000_0000,
		S_DONE  = 12'b1000_0000_0000
	} state_t;

	typedef enum logic [2:0] {
		JOB_ZM = 3'd0,
		JOB_PX = 3'd1,
		JOB_PY = 3'd2,
		JOB_VX = 3'd3,
		JOB_VY = 3'd4
	} job_t;

	localparam logic [1:0] OP_STEP   = 2'd0;
	localparam logic [1:0] OP_IMPACT = 2'd1;
	localparam logic [1:0] OP_RESET  = 2'd2;

	localparam logic [1:0] CFG_ZOOM = 2'd0;
	localparam logic [1:0] CFG_MODE = 2'd1;

	localparam logic [1:0] MODE_HEADING  = 2'd1;
	localparam logic [1:0] MODE_VELOCITY = 2'd2;

	localparam int DIV_W = 40;
	localparam int DTW   = 5;

	localparam logic [63:0] MIN_SPEED_SQ = 64'd703687;
	localparam logic [31:0] DECAY_PER_MS = 32'd4285089145;
	localparam logic [13:0] ZOOM_MIN     = 14'd410;
	localparam logic [13:0] ZOOM_MAX     = 14'd8192;
	localparam logic [13:0] ZOOM_GOAL_RST = 14'd1434;
	localparam logic [13:0] ZOOM_RST     = 14'd4096;
	localparam logic [32:0] IMPACT_GAIN  = 33'd15;

	localparam logic [9:0] DEN_ZM  = 10'd500;
	localparam logic [9:0] DEN_POS = 10'd100;
	localparam logic [9:0] DEN_VEL = 10'd1000;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [31:0] atan_entry(input logic [4:0] i);
		case (i)
			5'd0:  return 32'h20000000;
			5'd1:  return 32'h12E4051D;
			5'd2:  return 32'h09FB385B;
			5'd3:  return 32'h051111D4;
			5'd4:  return 32'h028B0D43;
			5'd5:  return 32'h0145D7E1;
			5'd6:  return 32'h00A2F61E;
			5'd7:  return 32'h00517C55;
			5'd8:  return 32'h0028BE53;
			5'd9:  return 32'h00145F2E;
			5'd10: return 32'h000A2F98;
			5'd11: return 32'h000517CC;
			5'd12: return 32'h00028BE6;
			5'd13: return 32'h000145F3;
			5'd14: return 32'h0000A2F9;
			5'd15: return 32'h0000517C;
			5'd16: return 32'h000028BE;
			5'd17: return 32'h0000145F;
			5'd18: return 32'h00000A2F;
			5'd19: return 32'h00000517;
			5'd20: return 32'h0000028B;
			5'd21: return 32'h00000145;
			5'd22: return 32'h000000A2;
			5'd23: return 32'h00000051;
			default: return 32'h0;
		endcase
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
		if (v > 42'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -42'sd2147483648)
			return 32'sh80000000;
		else
			return $signed(v[31:0]);
	endfunction

endpackage
`default_nettype wire

@@ rtl/tcf_cordic.sv @@
// Iterative vectoring CORDIC: one micro-rotation per cycle, atan2 of (x, y).
// Depends on tcf_pkg for the arctangent table.
`default_nettype none
module tcf_cordic #(
	parameter int ANGLE_BITS   = 16,
	parameter int CORDIC_STEPS = 14
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [31:0]      x_in,
	input  wire logic signed [31:0]      y_in,
	output logic                         done,
	output logic [ANGLE_BITS-1:0]        angle
);
	import tcf_pkg::*;

	localparam int NSTEP = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

	logic signed [35:0] x_q, y_q, xs, ys;
	logic [31:0]        z_q, at;
	logic [4:0]         i_q;
	logic               busy_q, done_q;
	logic [32:0]        zr;

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = atan_entry(i_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				if (i_q == 5'(NSTEP - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				i_q <= i_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// fold the left half plane onto the right
			if (x_in < 0) begin
				x_q <= -36'(x_in);
				y_q <= -36'(y_in);
				z_q <= 32'h80000000;
			end else begin
				x_q <= 36'(x_in);
				y_q <= 36'(y_in);
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

	assign zr    = {1'b0, z_q} + (33'd1 << (31 - ANGLE_BITS));
	assign angle = zr[31:32-ANGLE_BITS];
	assign done  = done_q;

endmodule
`default_nettype wire

@@ rtl/tcf_div.sv @@
// Radix-16 divider by a small constant denominator, one quotient digit per cycle,
// each digit found by comparing against the fifteen digit multiples of the denominator.
// Depends on tcf_pkg for the numerator width.
`default_nettype none
module tcf_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [tcf_pkg::DIV_W-1:0] num,
	input  wire logic [9:0]               den,
	output logic                          done,
	output logic [tcf_pkg::DIV_W-1:0]     quo
);
	import tcf_pkg::*;

	localparam int NDIG = DIV_W / 4;

	logic [DIV_W-1:0] num_q;
	logic [9:0]       rem_q, den_q;
	logic [3:0]       cnt_q;
	logic             busy_q, done_q;
	logic [13:0]      v, sub;
	logic [3:0]       qd;

	assign v = {rem_q, num_q[DIV_W-1 -: 4]};

	// digit = how many multiples of the denominator fit under the partial remainder
	always_comb begin
		qd = '0;
		for (int k = 1; k < 16; k++) begin
			if (v >= 14'(k) * {4'b0, den_q})
				qd = 4'(k);
		end
	end
	assign sub = {10'b0, qd} * {4'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 4'(NDIG - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	// quotient digits shift in where numerator digits leave
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= 10'(v - sub);
			num_q <= {num_q[DIV_W-5:0], qd};
		end
	end

	assign quo  = num_q;
	assign done = done_q;

endmodule
`default_nettype wire

@@ rtl/tracking_camera_follow_step_top.sv @@
// Tracking camera follower: sequencer, state registers, shared multiplier.
// Depends on tcf_pkg, tcf_cordic and tcf_div.
//
//  channel | signals                              | direction
//  in      | in_valid/in_ready, op..impact_amount | request in
//  out     | out_valid/out_ready, cam_*, shake    | result out
//  cfg     | cfg_valid/cfg_ready, cfg_index/data  | register write in
//
// An impact only adds to the shake level; a reset also runs the CORDIC in velocity mode.
// A time step runs the decay once per ms of dt, a divide for zoom when off goal and
// four for the pull with a target, plus the CORDIC in velocity mode. The radix-16
// divider and the per-ms decay loop take most of a step. in_ready
// is high only when idle; a finished result waits in the output register for out_ready.
// Reset is asynchronous; config is always accepted.
`default_nettype none
module tracking_camera_follow_step_top #(
	parameter int ANGLE_BITS   = 16,
	parameter int CORDIC_STEPS = 14,
	parameter int MAX_STEP_MS  = 10
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         op,
	input  wire logic [3:0]         dt_ms,
	input  wire logic               target_valid,
	input  wire logic signed [31:0] target_x,
	input  wire logic signed [31:0] target_y,
	input  wire logic signed [31:0] target_vx,
	input  wire logic signed [31:0] target_vy,
	input  wire logic [15:0]        target_heading,
	input  wire logic [15:0]        impact_amount,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      cam_x,
	output logic signed [31:0]      cam_y,
	output logic [15:0]             cam_angle,
	output logic [13:0]             cam_zoom,
	output logic [31:0]             shake_level,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [13:0]        cfg_data
);
	import tcf_pkg::*;

	localparam int AB = ANGLE_BITS;
	localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);
	localparam logic [AB-1:0] HALF    = AB'(1) << (AB - 1);

	state_t state_q;
	job_t   job_q;

	logic [1:0]         op_q;
	logic [DTW-1:0]     dt_q, dt_c, shk_cnt_q;
	logic               tv_q;
	logic signed [31:0] tx_q, ty_q, tvx_q, tvy_q;
	logic [15:0]        head_q, amt_q;

	logic signed [31:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;
	logic [AB-1:0]      angle_q;
	logic [13:0]        zoom_q, zoom_goal_q;
	logic [31:0]        shake_q;
	logic [1:0]         mode_q;

	logic [63:0]        acc_q;
	logic               use_cord_q, neg_q;

	logic signed [31:0] cam_x_q, cam_y_q;
	logic [15:0]        cam_angle_q;
	logic [13:0]        cam_zoom_q;
	logic [31:0]        shake_out_q;
	logic               out_valid_q;

	// shared multiplier
	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] mul_p;
	assign mul_p = mul_a * mul_b;

	// rotation step per dt
	logic [AB-1:0] step_tab [0:16];
	for (genvar g = 0; g <= 16; g++) begin : g_step
		localparam longint SV = (longint'(g) * (64'sd1 <<< AB) + 500) / 1000;
		assign step_tab[g] = AB'(SV);
	end

	logic cord_start, cord_done;
	logic [AB-1:0] cord_angle;
	tcf_cordic #(.ANGLE_BITS(AB), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cord_start),
		.x_in(tvx_q), .y_in(tvy_q), .done(cord_done), .angle(cord_angle)
	);

	logic div_start, div_done;
	logic [DIV_W-1:0] div_num, div_quo;
	logic [9:0] div_den;
	tcf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(div_num), .den(div_den), .done(div_done), .quo(div_quo)
	);

	assign dt_c = ({1'b0, dt_ms} > DTW'(MAX_STEP_MS)) ? DTW'(MAX_STEP_MS) : {1'b0, dt_ms};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQ1: begin
				mul_a = 34'(tvx_q);
				mul_b = 34'(tvx_q);
			end
			S_SQ2: begin
				mul_a = 34'(tvy_q);
				mul_b = 34'(tvy_q);
			end
			S_MOVX: begin
				mul_a = 34'(vel_x_q);
				mul_b = {29'b0, dt_q};
			end
			S_MOVY: begin
				mul_a = 34'(vel_y_q);
				mul_b = {29'b0, dt_q};
			end
			S_SHK: begin
				mul_a = {2'b0, shake_q};
				mul_b = {2'b0, DECAY_PER_MS};
			end
			S_DPREP: begin
				mul_b = {29'b0, dt_q};
				case (job_q)
					JOB_ZM: mul_a = {20'b0, zoom_q};
					JOB_PX: mul_a = 34'(tx_q) - 34'(pos_x_q);
					JOB_PY: mul_a = 34'(ty_q) - 34'(pos_y_q);
					JOB_VX: mul_a = 34'(vel_x_q) - 34'(tvx_q);
					JOB_VY: mul_a = 34'(vel_y_q) - 34'(tvy_q);
					default: mul_a = '0;
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// speed test, target angle and rotation step
	logic [63:0] sq;
	logic        fast;
	assign sq   = acc_q + mul_p[63:0];
	assign fast = sq > MIN_SPEED_SQ;

	logic [AB+15:0] head_w;
	logic [AB-1:0]  head_a, tgt, diff, mag, step;
	assign head_w = {head_q, {AB{1'b0}}};
	assign head_a = head_w[AB+15:16];
	assign tgt = (tv_q && (mode_q == MODE_HEADING || mode_q == MODE_VELOCITY)) ?
		((use_cord_q ? cord_angle : head_a) - QUARTER) : '0;
	assign diff = angle_q - tgt;
	assign mag  = (diff >= HALF) ? AB'(-diff) : diff;
	assign step = step_tab[dt_q];

	// motion
	logic signed [37:0] mv;
	logic signed [41:0] mv_sum_x, mv_sum_y;
	assign mv = $signed(mul_p[37:0]) + 38'sd128;
	assign mv_sum_x = 42'(pos_x_q) + 42'(mv >>> 8);
	assign mv_sum_y = 42'(pos_y_q) + 42'(mv >>> 8);

	// decay
	logic [63:0] dec;
	assign dec = mul_p[63:0] + 64'h80000000;

	// impact
	logic [32:0] imp;
	assign imp = {1'b0, shake_q} + 33'({amt_q, 8'b0}) * IMPACT_GAIN;

	// divide setup: floor((n + d/2) / d), negatives go through the magnitude
	logic signed [DIV_W-1:0] n_sgn, n_neg;
	logic [9:0] den_sel, add_sel;
	always_comb begin
		case (job_q)
			JOB_ZM: begin
				den_sel = DEN_ZM;
				add_sel = DEN_ZM >> 1;
			end
			JOB_PX, JOB_PY: begin
				den_sel = DEN_POS;
				add_sel = DEN_POS >> 1;
			end
			default: begin
				den_sel = DEN_VEL;
				add_sel = DEN_VEL >> 1;
			end
		endcase
	end
	assign n_sgn = $signed(mul_p[DIV_W-1:0]) + $signed({30'b0, add_sel});
	assign n_neg = -n_sgn + $signed({30'b0, den_sel}) - 40'sd1;
	assign div_num   = (n_sgn < 0) ? n_neg : n_sgn;
	assign div_den   = den_sel;
	assign div_start = (state_q == S_DPREP);

	logic signed [41:0] qs;
	logic [15:0] dz, dz1;
	assign qs  = neg_q ? -$signed({2'b0, div_quo}) : $signed({2'b0, div_quo});
	assign dz  = div_quo[15:0];
	assign dz1 = (dz == 16'd0) ? 16'd1 : dz;

	logic [16:0] z_up, z_lo;
	assign z_up = {3'b0, zoom_q} + {1'b0, dz1};
	assign z_lo = {3'b0, zoom_goal_q} + {1'b0, dz1};

	assign cord_start = (state_q == S_SQ2) && tv_q && (mode_q == MODE_VELOCITY) && fast;

	logic res_load;
	assign res_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			job_q       <= JOB_ZM;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			vel_x_q     <= '0;
			vel_y_q     <= '0;
			angle_q     <= '0;
			zoom_q      <= ZOOM_RST;
			shake_q     <= '0;
			zoom_goal_q <= ZOOM_GOAL_RST;
			mode_q      <= '0;
			out_valid_q <= 1'b0;
			use_cord_q  <= 1'b0;
			neg_q       <= 1'b0;
			shk_cnt_q   <= '0;
			acc_q       <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_ZOOM) begin
					if (cfg_data >= ZOOM_MIN && cfg_data <= ZOOM_MAX)
						zoom_goal_q <= cfg_data;
				end else if (cfg_index == CFG_MODE) begin
					mode_q <= cfg_data[1:0];
				end
			end
			if (res_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_START;
				end
				S_START: begin
					case (op_q)
						OP_STEP: state_q <= (dt_q == '0) ? S_DONE : S_SQ1;
						OP_IMPACT: begin
							shake_q <= imp[32] ? 32'hFFFFFFFF : imp[31:0];
							state_q <= S_DONE;
						end
						OP_RESET: state_q <= S_SQ1;
						default: state_q <= S_DONE;
					endcase
				end
				S_SQ1: begin
					acc_q   <= mul_p[63:0];
					state_q <= S_SQ2;
				end
				S_SQ2: begin
					use_cord_q <= cord_start;
					state_q    <= cord_start ? S_CORD : S_ANG;
				end
				S_CORD: begin
					if (cord_done)
						state_q <= S_ANG;
				end
				S_ANG: begin
					if (op_q == OP_RESET) begin
						if (tv_q) begin
							pos_x_q <= tx_q;
							pos_y_q <= ty_q;
						end
						vel_x_q <= '0;
						vel_y_q <= '0;
						shake_q <= '0;
						angle_q <= tgt;
						state_q <= S_DONE;
					end else begin
						if (diff != '0) begin
							if (mag < step)
								angle_q <= tgt;
							else if (diff >= HALF)
								angle_q <= angle_q + step;
							else
								angle_q <= angle_q - step;
						end
						state_q <= S_MOVX;
					end
				end
				S_MOVX: begin
					pos_x_q <= sat32(mv_sum_x);
					state_q <= S_MOVY;
				end
				S_MOVY: begin
					pos_y_q   <= sat32(mv_sum_y);
					shk_cnt_q <= dt_q;
					job_q     <= JOB_ZM;
					state_q   <= (zoom_q != zoom_goal_q) ? S_DPREP : S_SHK;
				end
				S_SHK: begin
					shake_q   <= dec[63:32];
					shk_cnt_q <= shk_cnt_q - DTW'(1);
					if (shk_cnt_q == DTW'(1)) begin
						job_q   <= JOB_PX;
						state_q <= tv_q ? S_DPREP : S_DONE;
					end
				end
				S_DPREP: begin
					neg_q   <= (n_sgn < 0);
					state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					if (div_done) begin
						case (job_q)
							JOB_ZM: begin
								if (zoom_q < zoom_goal_q)
									zoom_q <= (z_up > {3'b0, zoom_goal_q}) ?
										zoom_goal_q : z_up[13:0];
								else
									zoom_q <= ({3'b0, zoom_q} < z_lo) ?
										zoom_goal_q : 14'(zoom_q - dz1[13:0]);
								state_q <= S_SHK;
							end
							JOB_PX: begin
								pos_x_q <= sat32(42'(pos_x_q) + qs);
								job_q   <= JOB_PY;
								state_q <= S_DPREP;
							end
							JOB_PY: begin
								pos_y_q <= sat32(42'(pos_y_q) + qs);
								job_q   <= JOB_VX;
								state_q <= S_DPREP;
							end
							JOB_VX: begin
								vel_x_q <= sat32(42'(vel_x_q) - qs);
								job_q   <= JOB_VY;
								state_q <= S_DPREP;
							end
							default: begin
								vel_y_q <= sat32(42'(vel_y_q) - qs);
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_DONE: begin
					// hold until the previous result has been taken
					if (res_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	logic [AB+15:0] ang_w;
	assign ang_w = {angle_q, 16'b0};

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q   <= op;
			dt_q   <= dt_c;
			tv_q   <= target_valid;
			tx_q   <= target_x;
			ty_q   <= target_y;
			tvx_q  <= target_vx;
			tvy_q  <= target_vy;
			head_q <= target_heading;
			amt_q  <= impact_amount;
		end
		if (res_load) begin
			cam_x_q     <= pos_x_q;
			cam_y_q     <= pos_y_q;
			cam_angle_q <= ang_w[AB+15:AB];
			cam_zoom_q  <= zoom_q;
			shake_out_q <= shake_q;
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign cam_x       = cam_x_q;
	assign cam_y       = cam_y_q;
	assign cam_angle   = cam_angle_q;
	assign cam_zoom    = cam_zoom_q;
	assign shake_level = shake_out_q;

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_START))
		else $error("accepted request did not start the sequencer");
	a_cord_done: assert property (@(posedge clk) disable iff (!arst_n)
		cord_done |-> (state_q == S_CORD))
		else $error("CORDIC finished outside its wait state");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DWAIT))
		else $error("divider finished outside its wait state");
	a_zoom_range: assert property (@(posedge clk) disable iff (!arst_n)
		(zoom_q >= ZOOM_MIN) && (zoom_q <= ZOOM_MAX))
		else $error("zoom left its legal range");

endmodule
`default_nettype wire

@@ test/tracking_camera_follow_step_top_tb.sv @@
// Self-checking testbench for the tracking camera follower: directed and random
// camera requests, zoom and mode register writes, random stalls on both sides.
// Depends on tcf_pkg and tracking_camera_follow_step_top.
`default_nettype none
module tracking_camera_follow_step_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tcf_pkg::*;

	localparam logic [1:0] OP_SPARE   = 2'd3;
	localparam logic [1:0] MODE_NONE  = 2'd0;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [1:0] CFG_SPARE  = 2'd2;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct {
		logic [1:0]         op;
		logic [3:0]         dt;
		logic               tv;
		logic signed [31:0] tx, ty, tvx, tvy;
		logic [15:0]        hd, imp;
	} cam_req_t;

	typedef struct {
		logic signed [31:0] x, y;
		logic [15:0]        angle;
		logic [13:0]        zoom;
		logic [31:0]        shake;
	} cam_view_t;

	class camera_tracker;
		int signed   px, py, vx, vy;
		bit [15:0]   ang;
		bit [13:0]   zoom, zoom_goal;
		bit [1:0]    mode;
		bit [31:0]   shk;
		cam_view_t   views[$];
		int          errors;
		bit [31:0]   atan_lut[14] = '{
			32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
			32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
			32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3};

		function new();
			px = 0; py = 0; vx = 0; vy = 0; ang = 0; zoom = 14'd4096; shk = 0;
			zoom_goal = 14'd1434; mode = MODE_NONE; errors = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [13:0] data);
			if (idx == CFG_ZOOM) begin
				if (data >= 14'd410 && data <= 14'd8192) zoom_goal = data;
			end else if (idx == CFG_MODE) begin
				mode = data[1:0];
			end
		endfunction

		function int signed clip(longint v);
			if (v > 64'sd2147483647) return 32'sh7fffffff;
			if (v < -64'sd2147483648) return 32'sh80000000;
			return int'(v);
		endfunction

		function longint rdiv(longint n, longint d);
			longint q;
			n = n + d / 2;
			q = n / d;
			if (n % d < 0) q--;
			return q;
		endfunction

		function bit [15:0] heading_of(longint x, longint y);
			bit [31:0] z;
			longint nx;
			z = 0;
			if (x < 0) begin
				x = -x; y = -y; z = 32'h80000000;
			end
			for (int i = 0; i < 14; i++) begin
				if (y >= 0) begin
					nx = x + (y >>> i); y = y - (x >>> i); z = z + atan_lut[i];
				end else begin
					nx = x - (y >>> i); y = y + (x >>> i); z = z - atan_lut[i];
				end
				x = nx;
			end
			return 16'((longint'(z) + 64'd32768) >> 16);
		endfunction

		function bit [15:0] aim(cam_req_t r);
			bit [15:0] head;
			longint sx, sy;
			longint unsigned sq;
			head = r.hd;
			if (!r.tv) return 16'd0;
			if (mode != MODE_HEADING && mode != MODE_VELOCITY) return 16'd0;
			if (mode == MODE_VELOCITY) begin
				sx = r.tvx; sy = r.tvy;
				sq = longint'(sx * sx) + longint'(sy * sy);
				if (sq > 64'd703687) head = heading_of(sx, sy);
			end
			return head - 16'h4000;
		endfunction

		function void advance(cam_req_t r, longint dt);
			bit [15:0] tgt, diff, mag;
			longint stp;
			longint unsigned dz;
			tgt = aim(r);
			stp = (dt * 65536 + 500) / 1000;
			px = clip(longint'(px) + ((longint'(vx) * dt + 128) >>> 8));
			py = clip(longint'(py) + ((longint'(vy) * dt + 128) >>> 8));
			diff = ang - tgt;
			if (diff != 0) begin
				mag = diff[15] ? 16'(17'h10000 - diff) : diff;
				if (mag < stp) ang = tgt;
				else if (diff[15]) ang = ang + 16'(stp);
				else ang = ang - 16'(stp);
			end
			if (zoom != zoom_goal) begin
				dz = (longint'(zoom) * dt + 250) / 500;
				if (dz == 0) dz = 1;
				if (zoom < zoom_goal)
					zoom = (zoom + dz > zoom_goal) ? zoom_goal : 14'(zoom + dz);
				else
					zoom = (zoom < zoom_goal + dz) ? zoom_goal : 14'(zoom - dz);
			end
			for (int k = 0; k < dt; k++)
				shk = 32'((longint'(shk) * 64'd4285089145 + 64'h80000000) >> 32);
			if (r.tv) begin
				px = clip(longint'(px) + rdiv((longint'(r.tx) - px) * dt, 100));
				py = clip(longint'(py) + rdiv((longint'(r.ty) - py) * dt, 100));
				vx = clip(longint'(vx) - rdiv((longint'(vx) - r.tvx) * dt, 1000));
				vy = clip(longint'(vy) - rdiv((longint'(vy) - r.tvy) * dt, 1000));
			end
		endfunction

		function void note_request(cam_req_t r);
			longint dt, s;
			cam_view_t v;
			dt = (r.dt > 4'd10) ? 10 : r.dt;
			case (r.op)
				OP_STEP: if (dt != 0) advance(r, dt);
				OP_IMPACT: begin
					s = longint'(shk) + ((longint'(r.imp) * 15) << 8);
					shk = (s > 64'hFFFFFFFF) ? 32'hFFFFFFFF : 32'(s);
				end
				OP_RESET: begin
					if (r.tv) begin
						px = r.tx; py = r.ty;
					end
					vx = 0; vy = 0; shk = 0;
					ang = aim(r);
				end
				default: ;
			endcase
			v.x = px; v.y = py; v.angle = ang; v.zoom = zoom; v.shake = shk;
			views.push_back(v);
		endfunction

		function void check_view(cam_view_t a);
			cam_view_t e;
			if (views.size() == 0) begin
				$error("unexpected result: cam_x=%0d cam_y=%0d", a.x, a.y);
				errors++;
				return;
			end
			e = views.pop_front();
			if (a.x !== e.x) begin
				$error("cam_x: expected %0d, got %0d", e.x, a.x); errors++;
			end
			if (a.y !== e.y) begin
				$error("cam_y: expected %0d, got %0d", e.y, a.y); errors++;
			end
			if (a.angle !== e.angle) begin
				$error("cam_angle: expected %0d, got %0d", e.angle, a.angle); errors++;
			end
			if (a.zoom !== e.zoom) begin
				$error("cam_zoom: expected %0d, got %0d", e.zoom, a.zoom); errors++;
			end
			if (a.shake !== e.shake) begin
				$error("shake_level: expected %0d, got %0d", e.shake, a.shake); errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	logic [1:0] op, cfg_index;
	logic [3:0] dt_ms;
	logic target_valid;
	logic signed [31:0] target_x, target_y, target_vx, target_vy, cam_x, cam_y;
	logic [15:0] target_heading, impact_amount, cam_angle;
	logic [13:0] cam_zoom, cfg_data;
	logic [31:0] shake_level;

	camera_tracker tracker = new();
	bit burst_in, burst_out;
	int cycles;

	tracking_camera_follow_step_top i_dut (.*);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Result side: random stall per result, none during bursts.
	initial begin
		int stall;
		cam_view_t got;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = burst_out ? 0 : $urandom_range(0, 11);
			@(negedge clk);
			out_ready = 1'b0;
			repeat (stall) @(negedge clk);
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			got.x = cam_x; got.y = cam_y; got.angle = cam_angle;
			got.zoom = cam_zoom; got.shake = shake_level;
			tracker.check_view(got);
		end
	end

	task automatic send_request(cam_req_t r);
		int gap;
		gap = burst_in ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		op = r.op; dt_ms = r.dt; target_valid = r.tv;
		target_x = r.tx; target_y = r.ty; target_vx = r.tvx; target_vy = r.tvy;
		target_heading = r.hd; impact_amount = r.imp;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		tracker.note_request(r);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (tracker.views.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [13:0] data);
		@(negedge clk);
		cfg_index = idx; cfg_data = data; cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic signed [31:0] coord(int near_span);
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom_range(0, 2 * near_span)) - near_span;
		endcase
	endfunction

	function automatic cam_req_t random_request();
		cam_req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		r.op = pick < 70 ? OP_STEP : pick < 82 ? OP_IMPACT : pick < 95 ? OP_RESET : OP_SPARE;
		r.dt = $urandom_range(0, 9) == 0 ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 10));
		r.tv = $urandom_range(0, 6) != 0;
		r.tx = coord(1 << 22);
		r.ty = coord(1 << 22);
		// Mix crawling speeds (near the direction threshold) with fast ones.
		r.tvx = $urandom_range(0, 2) == 0 ? coord(600) : coord(1 << 25);
		r.tvy = $urandom_range(0, 2) == 0 ? coord(600) : coord(1 << 25);
		r.hd = 16'($urandom());
		r.imp = $urandom_range(0, 7) == 0 ? 16'hFFFF : 16'($urandom());
		return r;
	endfunction

	function automatic cam_req_t make_request(logic [1:0] o, logic [3:0] d, logic v,
			int signed x, int signed y, int signed qx, int signed qy,
			logic [15:0] h, logic [15:0] imp);
		cam_req_t r;
		r.op = o; r.dt = d; r.tv = v; r.tx = x; r.ty = y;
		r.tvx = qx; r.tvy = qy; r.hd = h; r.imp = imp;
		return r;
	endfunction

	initial begin
		logic [13:0] zoom_list[8] = '{14'd410, 14'd8192, 14'd409, 14'd8193, 14'd16383,
			14'd2048, 14'd4096, 14'd410};
		logic [13:0] mode_list[8] = '{14'd1, 14'd2, 14'd3, 14'd6, 14'd0, 14'd2, 14'd1, 14'd2};
		arst_n = 1'b0; in_valid = 1'b0; cfg_valid = 1'b0;
		op = OP_STEP; dt_ms = 4'd0; target_valid = 1'b0;
		target_x = 0; target_y = 0; target_vx = 0; target_vy = 0;
		target_heading = 0; impact_amount = 0; cfg_index = CFG_ZOOM; cfg_data = 0;
		burst_in = 1'b0; burst_out = 1'b0; cycles = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset defaults first, then heading and velocity modes.
		send_request(make_request(OP_STEP, 4'd1, 1'b0, 0, 0, 0, 0, 16'h0, 16'h0));
		send_request(make_request(OP_RESET, 4'd5, 1'b1, 32'sh7fffffff, 32'sh80000000,
			0, 0, 16'hFFFF, 16'h0));
		send_request(make_request(OP_STEP, 4'd10, 1'b1, 32'sh80000000, 32'sh7fffffff,
			32'sh7fffffff, 32'sh80000000, 16'h0, 16'h0));
		send_request(make_request(OP_STEP, 4'd0, 1'b1, 100, 100, 0, 0, 16'h0, 16'h0));
		send_request(make_request(OP_STEP, 4'd15, 1'b1, 0, 0, 0, 0, 16'h0, 16'h0));
		send_request(make_request(OP_IMPACT, 4'd0, 1'b0, 0, 0, 0, 0, 16'h0, 16'hFFFF));
		send_request(make_request(OP_IMPACT, 4'd0, 1'b0, 0, 0, 0, 0, 16'h0, 16'hFFFF));
		send_request(make_request(OP_SPARE, 4'd3, 1'b1, 5, 5, 5, 5, 16'h1234, 16'h1));
		send_request(make_request(OP_STEP, 4'd10, 1'b0, 0, 0, 0, 0, 16'h0, 16'h0));
		send_request(make_request(OP_RESET, 4'd1, 1'b0, 0, 0, 0, 0, 16'h0, 16'h0));
		settle();
		write_reg(CFG_MODE, 14'(MODE_HEADING));
		write_reg(CFG_ZOOM, 14'd8192);
		send_request(make_request(OP_RESET, 4'd1, 1'b1, 0, 0, 0, 0, 16'h4000, 16'h0));
		// Half-turn gap first, then further steps toward a slightly moved heading.
		send_request(make_request(OP_STEP, 4'd1, 1'b1, 0, 0, 0, 0, 16'hC000, 16'h0));
		send_request(make_request(OP_STEP, 4'd10, 1'b1, 0, 0, 0, 0, 16'hC000, 16'h0));
		send_request(make_request(OP_STEP, 4'd1, 1'b1, 0, 0, 0, 0, 16'hC030, 16'h0));
		settle();
		write_reg(CFG_MODE, 14'(MODE_VELOCITY));
		write_reg(CFG_SPARE, 14'h3FFF);
		send_request(make_request(OP_STEP, 4'd4, 1'b1, 0, 0, 593, 593, 16'h2000, 16'h0));
		send_request(make_request(OP_STEP, 4'd4, 1'b1, 0, 0, 594, 593, 16'h2000, 16'h0));
		send_request(make_request(OP_RESET, 4'd4, 1'b1, 0, 0, -1 << 24, -1, 16'h0, 16'h0));
		send_request(make_request(OP_RESET, 4'd4, 1'b1, 0, 0, 32'sh80000000,
			32'sh80000000, 16'h0, 16'h0));
		send_request(make_request(OP_STEP, 4'd7, 1'b1, 0, 0, 0, 1 << 24, 16'h0, 16'h0));
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(CFG_ZOOM, zoom_list[ph]);
			write_reg(CFG_MODE, mode_list[ph]);
			for (int n = 0; n < 85; n++) begin
				if (n % 20 == 0) begin
					burst_in = $urandom_range(0, 2) == 0;
					burst_out = $urandom_range(0, 2) == 0;
				end
				send_request(random_request());
			end
			settle();
		end

		repeat (300) @(posedge clk);
		if (tracker.errors == 0 && tracker.views.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
`default_nettype wire
